// File: src/owm_pkg.sv
// owm_pkg: shared types and constants of the 1-Wire bus master
// item and result records, command codes, slot phase encoding, slot durations
// no dependencies
package owm_pkg;

   // command codes carried in the mode field
   localparam logic [2:0] MODE_TICK       = 3'd0;
   localparam logic [2:0] MODE_RESET_PRES = 3'd1;
   localparam logic [2:0] MODE_WRITE_BYTE = 3'd2;
   localparam logic [2:0] MODE_READ_BYTE  = 3'd3;
   localparam logic [2:0] MODE_WRITE_BIT  = 3'd4;
   localparam logic [2:0] MODE_READ_BIT   = 3'd5;

   localparam int TPU_WIDTH   = 7;
   localparam int US_WIDTH    = 9;
   localparam int COUNT_WIDTH = 16;

   localparam logic [TPU_WIDTH-1:0] TPU_RESET = 7'd2;

   // slot durations in microseconds
   localparam logic [US_WIDTH-1:0] US_PRES_LOW  = 9'd480;
   localparam logic [US_WIDTH-1:0] US_PRES_WAIT = 9'd70;
   localparam logic [US_WIDTH-1:0] US_PRES_REC  = 9'd410;
   localparam logic [US_WIDTH-1:0] US_W1_LOW    = 9'd6;
   localparam logic [US_WIDTH-1:0] US_W0_LOW    = 9'd60;
   localparam logic [US_WIDTH-1:0] US_W1_REC    = 9'd64;
   localparam logic [US_WIDTH-1:0] US_W0_REC    = 9'd10;
   localparam logic [US_WIDTH-1:0] US_RD_LOW    = 9'd6;
   localparam logic [US_WIDTH-1:0] US_RD_WAIT   = 9'd9;
   localparam logic [US_WIDTH-1:0] US_RD_REC    = 9'd55;

   // slot phases, one-hot
   typedef enum logic [10:0] {
      PH_IDLE      = 11'b000_0000_0001,
      PH_PRES_LOW  = 11'b000_0000_0010,
      PH_PRES_WAIT = 11'b000_0000_0100,
      PH_PRES_REC  = 11'b000_0000_1000,
      PH_W1_LOW    = 11'b000_0001_0000,
      PH_W1_REC    = 11'b000_0010_0000,
      PH_W0_LOW    = 11'b000_0100_0000,
      PH_W0_REC    = 11'b000_1000_0000,
      PH_RD_LOW    = 11'b001_0000_0000,
      PH_RD_WAIT   = 11'b010_0000_0000,
      PH_RD_REC    = 11'b100_0000_0000
   } phase_type;

   // one request
   typedef struct packed {
      logic [2:0] mode;
      logic [7:0] write_data;
      logic       bus_level;
   } req_item_type;

   // one result
   typedef struct packed {
      logic       bus_drive_low;
      logic       idle;
      logic       command_rejected;
      logic       presence_done;
      logic       presence_found;
      logic       read_done;
      logic [7:0] read_value;
      logic       write_done;
   } rsp_item_type;

endpackage

// File: src/owm_in_stage.sv
// owm_in_stage: input register of the 1-Wire bus master
// holds one request until the engine takes it; uses owm_pkg
module owm_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  owm_pkg::req_item_type req_item,
   input  logic                  take,
   output logic                  item_valid,
   output owm_pkg::req_item_type item
);
   import owm_pkg::*;

   logic         valid_ff, valid_in;
   req_item_type item_ff;

   // room when empty or when the held request leaves this cycle
   assign req_ready  = !valid_ff || take;
   assign valid_in   = (req_valid && req_ready) || (valid_ff && !take);
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

endmodule

// File: src/owm_engine.sv
// owm_engine: slot phase machine, countdown, shift register and rate register
// one request is applied per step; uses owm_pkg
module owm_engine (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [6:0]                csr_wr_data,
   input  logic                      step,
   input  owm_pkg::req_item_type     item,
   output owm_pkg::rsp_item_type     result
);
   import owm_pkg::*;

   logic [TPU_WIDTH-1:0]   tpu_ff;
   phase_type              phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [7:0]             shift_ff, shift_in;
   logic [2:0]             bits_ff, bits_in;
   logic                   single_ff, single_in;
   logic                   pres_ff, pres_in;

   logic                   load_en;
   logic [US_WIDTH-1:0]    load_us;
   logic [COUNT_WIDTH-1:0] product;
   logic [COUNT_WIDTH-1:0] load_count;
   logic                   is_cmd;
   logic                   rejected, pres_done, rd_done, wr_done;

   // slot length in ticks, at least one
   assign product    = COUNT_WIDTH'(load_us * tpu_ff);
   assign load_count = (product == '0) ? COUNT_WIDTH'(1) : product;
   assign is_cmd     = (item.mode >= MODE_RESET_PRES) && (item.mode <= MODE_READ_BIT);

   // next state for one request
   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      shift_in  = shift_ff;
      bits_in   = bits_ff;
      single_in = single_ff;
      pres_in   = pres_ff;
      load_en   = 1'b0;
      load_us   = US_PRES_LOW;
      rejected  = 1'b0;
      pres_done = 1'b0;
      rd_done   = 1'b0;
      wr_done   = 1'b0;
      if (is_cmd) begin
         if (phase_ff != PH_IDLE) begin
            rejected = 1'b1;
         end else begin
            case (item.mode)
               MODE_RESET_PRES: begin
                  pres_in  = 1'b0;
                  phase_in = PH_PRES_LOW;
                  load_en  = 1'b1;
                  load_us  = US_PRES_LOW;
               end
               MODE_WRITE_BYTE, MODE_WRITE_BIT: begin
                  single_in = (item.mode == MODE_WRITE_BIT);
                  bits_in   = (item.mode == MODE_WRITE_BIT) ? 3'd0 : 3'd7;
                  shift_in  = (item.mode == MODE_WRITE_BIT) ? 8'h00
                                                            : {1'b0, item.write_data[7:1]};
                  phase_in  = item.write_data[0] ? PH_W1_LOW : PH_W0_LOW;
                  load_en   = 1'b1;
                  load_us   = item.write_data[0] ? US_W1_LOW : US_W0_LOW;
               end
               default: begin
                  single_in = (item.mode == MODE_READ_BIT);
                  bits_in   = (item.mode == MODE_READ_BIT) ? 3'd0 : 3'd7;
                  shift_in  = 8'h00;
                  phase_in  = PH_RD_LOW;
                  load_en   = 1'b1;
                  load_us   = US_RD_LOW;
               end
            endcase
         end
      end else if (item.mode == MODE_TICK && phase_ff != PH_IDLE) begin
         if (count_ff > COUNT_WIDTH'(1)) begin
            count_in = count_ff - COUNT_WIDTH'(1);
         end else begin
            case (phase_ff)
               PH_PRES_LOW: begin
                  phase_in = PH_PRES_WAIT;
                  load_en  = 1'b1;
                  load_us  = US_PRES_WAIT;
               end
               PH_PRES_WAIT: begin
                  pres_in  = !item.bus_level;
                  phase_in = PH_PRES_REC;
                  load_en  = 1'b1;
                  load_us  = US_PRES_REC;
               end
               PH_PRES_REC: begin
                  phase_in  = PH_IDLE;
                  count_in  = '0;
                  pres_done = 1'b1;
               end
               PH_W1_LOW: begin
                  phase_in = PH_W1_REC;
                  load_en  = 1'b1;
                  load_us  = US_W1_REC;
               end
               PH_W0_LOW: begin
                  phase_in = PH_W0_REC;
                  load_en  = 1'b1;
                  load_us  = US_W0_REC;
               end
               PH_W1_REC, PH_W0_REC: begin
                  if (bits_ff != 3'd0) begin
                     bits_in  = bits_ff - 3'd1;
                     phase_in = shift_ff[0] ? PH_W1_LOW : PH_W0_LOW;
                     load_en  = 1'b1;
                     load_us  = shift_ff[0] ? US_W1_LOW : US_W0_LOW;
                     shift_in = {1'b0, shift_ff[7:1]};
                  end else begin
                     phase_in = PH_IDLE;
                     count_in = '0;
                     wr_done  = 1'b1;
                  end
               end
               PH_RD_LOW: begin
                  phase_in = PH_RD_WAIT;
                  load_en  = 1'b1;
                  load_us  = US_RD_WAIT;
               end
               PH_RD_WAIT: begin
                  shift_in = single_ff ? {7'd0, item.bus_level}
                                       : {item.bus_level, shift_ff[7:1]};
                  phase_in = PH_RD_REC;
                  load_en  = 1'b1;
                  load_us  = US_RD_REC;
               end
               PH_RD_REC: begin
                  if (bits_ff != 3'd0) begin
                     bits_in  = bits_ff - 3'd1;
                     phase_in = PH_RD_LOW;
                     load_en  = 1'b1;
                     load_us  = US_RD_LOW;
                  end else begin
                     phase_in = PH_IDLE;
                     count_in = '0;
                     rd_done  = 1'b1;
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
                  count_in = '0;
               end
            endcase
         end
      end
      if (load_en) begin
         count_in = load_count;
      end
   end

   // result fields follow the phase after this request
   always_comb begin
      result.bus_drive_low    = (phase_in == PH_PRES_LOW) || (phase_in == PH_W1_LOW) ||
                                (phase_in == PH_W0_LOW) || (phase_in == PH_RD_LOW);
      result.idle             = (phase_in == PH_IDLE);
      result.command_rejected = rejected;
      result.presence_done    = pres_done;
      result.presence_found   = pres_in;
      result.read_done        = rd_done;
      result.read_value       = rd_done ? shift_ff : 8'h00;
      result.write_done       = wr_done;
   end

   // rate register
   always_ff @(posedge clock) begin
      if (reset) begin
         tpu_ff <= TPU_RESET;
      end else if (csr_wr_en) begin
         tpu_ff <= csr_wr_data;
      end
   end

   // sequence state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         count_ff  <= '0;
         shift_ff  <= 8'hFF;
         bits_ff   <= 3'd0;
         single_ff <= 1'b0;
         pres_ff   <= 1'b0;
      end else if (step) begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         shift_ff  <= shift_in;
         bits_ff   <= bits_in;
         single_ff <= single_in;
         pres_ff   <= pres_in;
      end
   end

endmodule

// File: src/onewire_bus_master.sv
// onewire_bus_master: top level of the single-device 1-Wire bus master
// input register, slot engine and result register; uses owm_pkg, owm_in_stage, owm_engine
//
// Each request is one tick (mode 0) or one command (modes 1 to 5); every request gives
// exactly one response carrying the line drive level, idle flag and done pulses. A request
// is registered in the input stage, applied to the phase machine and written to the response
// register; with rsp_ready high the block takes one request per clock. The slot timing is
// counted in tick requests, csr_wr_data ticks per microsecond (reset value 2, zero counts as
// one tick per slot); write it only while the bus is idle. Commands sent while a sequence
// runs are answered with command_rejected and otherwise ignored; modes 6 and 7 do nothing.
module onewire_bus_master (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_mode,
   input  logic [7:0] req_write_data,
   input  logic       req_bus_level,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_bus_drive_low,
   output logic       rsp_idle,
   output logic       rsp_command_rejected,
   output logic       rsp_presence_done,
   output logic       rsp_presence_found,
   output logic       rsp_read_done,
   output logic [7:0] rsp_read_value,
   output logic       rsp_write_done,
   input  logic       csr_wr_en,
   input  logic [6:0] csr_wr_data
);
   import owm_pkg::*;

   req_item_type req_item, item;
   rsp_item_type result, rsp_ff;
   logic         item_valid, step, rsp_valid_ff, rsp_valid_in;

   assign req_item.mode       = req_mode;
   assign req_item.write_data = req_write_data;
   assign req_item.bus_level  = req_bus_level;

   // engine steps when a request is held and the response slot is free
   assign step = item_valid && (!rsp_valid_ff || rsp_ready);

   owm_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .take       (step),
      .item_valid (item_valid),
      .item       (item)
   );

   owm_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .step        (step),
      .item        (item),
      .result      (result)
   );

   // response register
   assign rsp_valid_in = step || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_bus_drive_low    = rsp_ff.bus_drive_low;
   assign rsp_idle             = rsp_ff.idle;
   assign rsp_command_rejected = rsp_ff.command_rejected;
   assign rsp_presence_done    = rsp_ff.presence_done;
   assign rsp_presence_found   = rsp_ff.presence_found;
   assign rsp_read_done        = rsp_ff.read_done;
   assign rsp_read_value       = rsp_ff.read_value;
   assign rsp_write_done       = rsp_ff.write_done;

endmodule

// File: src/owm_checker.sv
// owm_checker: port-level checks of the 1-Wire bus master response stream
// bound to onewire_bus_master; no package use
module owm_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_bus_drive_low,
   input logic       rsp_idle,
   input logic       rsp_command_rejected,
   input logic       rsp_presence_done,
   input logic       rsp_read_done,
   input logic [7:0] rsp_read_value,
   input logic       rsp_write_done
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_value) && $stable(rsp_idle))
      else $error("response changed while stalled");

   // read byte shows only with its done pulse
   a_read_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_read_done |-> rsp_read_value == 8'h00)
      else $error("read value without read done");

   // a finished sequence leaves the bus idle, and only one finishes at a time
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_presence_done || rsp_read_done || rsp_write_done) |->
         rsp_idle && $onehot({rsp_presence_done, rsp_read_done, rsp_write_done}))
      else $error("done pulse while busy or more than one done");

   // line is driven only inside a sequence
   a_drive_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bus_drive_low |-> !rsp_idle)
      else $error("line driven while idle");

   // a rejected command means a sequence is running
   a_reject_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_command_rejected |-> !rsp_idle && !rsp_read_done && !rsp_write_done)
      else $error("command rejected while idle");

endmodule

bind onewire_bus_master owm_checker u_owm_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_bus_drive_low    (rsp_bus_drive_low),
   .rsp_idle             (rsp_idle),
   .rsp_command_rejected (rsp_command_rejected),
   .rsp_presence_done    (rsp_presence_done),
   .rsp_read_done        (rsp_read_done),
   .rsp_read_value       (rsp_read_value),
   .rsp_write_done       (rsp_write_done)
);

// File: tb/tb_onewire_bus_master.sv
// tb_onewire_bus_master: self-checking testbench for the single-device 1-Wire bus master
// drives tick and command requests with random stalls and checks every response field
// depends on owm_pkg and onewire_bus_master
module tb_onewire_bus_master;
   import owm_pkg::*;

   // mode codes the block ignores entirely
   localparam logic [2:0] MODE_UNUSED_6 = 3'd6;
   localparam logic [2:0] MODE_UNUSED_7 = 3'd7;
   localparam int STALL_LIMIT = 2000;
   localparam int RSP_HOLD_CYCLES = 150;
   localparam int PHASE_REQUESTS = 160;

   // shadow of the bus master: slot phase machine plus the queue of awaited responses
   class slot_tracker;
      phase_type    phase;
      logic [15:0]  countdown;
      logic [7:0]   shift_byte;
      logic [3:0]   bits_left;
      logic         single_bit;
      logic         presence_seen;
      logic [6:0]   rate;
      rsp_item_type awaited_responses[$];
      int           mismatches;

      function new();
         rate          = TPU_RESET;
         phase         = PH_IDLE;
         countdown     = '0;
         shift_byte    = 8'hFF;
         bits_left     = '0;
         single_bit    = 1'b0;
         presence_seen = 1'b0;
         mismatches    = 0;
      endfunction

      function void set_rate(logic [6:0] value);
         rate = value;
      endfunction

      // slot length in ticks, a zero product counts as one tick
      function void load_slot(logic [US_WIDTH-1:0] us);
         logic [31:0] product;
         product   = 32'(us) * 32'(rate);
         countdown = (product[15:0] == 16'd0) ? 16'd1 : product[15:0];
      endfunction

      function void start_write_slot(logic value);
         if (value) begin
            phase = PH_W1_LOW;
            load_slot(US_W1_LOW);
         end else begin
            phase = PH_W0_LOW;
            load_slot(US_W0_LOW);
         end
      endfunction

      function void start_read_slot();
         phase = PH_RD_LOW;
         load_slot(US_RD_LOW);
      endfunction

      // advance the shadow by one accepted request and queue the response it gives
      function void note_request(req_item_type r);
         rsp_item_type o;
         o = '0;
         if (r.mode >= MODE_RESET_PRES && r.mode <= MODE_READ_BIT) begin
            if (phase != PH_IDLE) begin
               o.command_rejected = 1'b1;
            end else begin
               case (r.mode)
                  MODE_RESET_PRES: begin
                     presence_seen = 1'b0;
                     phase = PH_PRES_LOW;
                     load_slot(US_PRES_LOW);
                  end
                  MODE_WRITE_BYTE, MODE_WRITE_BIT: begin
                     single_bit = (r.mode == MODE_WRITE_BIT);
                     bits_left  = single_bit ? 4'd0 : 4'd7;
                     start_write_slot(r.write_data[0]);
                     shift_byte = single_bit ? 8'h00 : {1'b0, r.write_data[7:1]};
                  end
                  default: begin
                     single_bit = (r.mode == MODE_READ_BIT);
                     bits_left  = single_bit ? 4'd0 : 4'd7;
                     shift_byte = 8'h00;
                     start_read_slot();
                  end
               endcase
            end
         end else if (r.mode == MODE_TICK && phase != PH_IDLE) begin
            if (countdown > 16'd1) begin
               countdown--;
            end else begin
               case (phase)
                  PH_PRES_LOW: begin
                     phase = PH_PRES_WAIT;
                     load_slot(US_PRES_WAIT);
                  end
                  PH_PRES_WAIT: begin
                     presence_seen = !r.bus_level;
                     phase = PH_PRES_REC;
                     load_slot(US_PRES_REC);
                  end
                  PH_PRES_REC: begin
                     phase = PH_IDLE;
                     countdown = '0;
                     o.presence_done = 1'b1;
                  end
                  PH_W1_LOW: begin
                     phase = PH_W1_REC;
                     load_slot(US_W1_REC);
                  end
                  PH_W0_LOW: begin
                     phase = PH_W0_REC;
                     load_slot(US_W0_REC);
                  end
                  PH_W1_REC, PH_W0_REC: begin
                     if (bits_left != 4'd0) begin
                        bits_left--;
                        start_write_slot(shift_byte[0]);
                        shift_byte = shift_byte >> 1;
                     end else begin
                        phase = PH_IDLE;
                        countdown = '0;
                        o.write_done = 1'b1;
                     end
                  end
                  PH_RD_LOW: begin
                     phase = PH_RD_WAIT;
                     load_slot(US_RD_WAIT);
                  end
                  PH_RD_WAIT: begin
                     // sample point: single bit lands in bit 0, bytes shift in from the top
                     if (single_bit) shift_byte = {7'd0, r.bus_level};
                     else shift_byte = {r.bus_level, shift_byte[7:1]};
                     phase = PH_RD_REC;
                     load_slot(US_RD_REC);
                  end
                  PH_RD_REC: begin
                     if (bits_left != 4'd0) begin
                        bits_left--;
                        start_read_slot();
                     end else begin
                        phase = PH_IDLE;
                        countdown = '0;
                        o.read_done = 1'b1;
                        o.read_value = shift_byte;
                     end
                  end
                  default: begin
                     phase = PH_IDLE;
                     countdown = '0;
                  end
               endcase
            end
         end
         o.bus_drive_low = (phase == PH_PRES_LOW) || (phase == PH_W1_LOW) ||
                           (phase == PH_W0_LOW) || (phase == PH_RD_LOW);
         o.idle = (phase == PH_IDLE);
         o.presence_found = presence_seen;
         awaited_responses.push_back(o);
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            mismatches++;
         end
      endfunction

      // compare one accepted response with the oldest awaited one
      function void check_response(rsp_item_type got);
         rsp_item_type want;
         if (awaited_responses.size() == 0) begin
            $display("%0t: response %h expected none got one", $time, got);
            mismatches++;
            return;
         end
         want = awaited_responses.pop_front();
         compare_field("bus_drive_low", want.bus_drive_low, got.bus_drive_low);
         compare_field("idle", want.idle, got.idle);
         compare_field("command_rejected", want.command_rejected, got.command_rejected);
         compare_field("presence_done", want.presence_done, got.presence_done);
         compare_field("presence_found", want.presence_found, got.presence_found);
         compare_field("read_done", want.read_done, got.read_done);
         compare_field("read_value", want.read_value, got.read_value);
         compare_field("write_done", want.write_done, got.write_done);
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [2:0] req_mode;
   logic [7:0] req_write_data;
   logic       req_bus_level;
   logic       rsp_valid;
   logic       rsp_ready;
   logic       rsp_bus_drive_low;
   logic       rsp_idle;
   logic       rsp_command_rejected;
   logic       rsp_presence_done;
   logic       rsp_presence_found;
   logic       rsp_read_done;
   logic [7:0] rsp_read_value;
   logic       rsp_write_done;
   logic       csr_wr_en;
   logic [6:0] csr_wr_data;

   slot_tracker tracker;
   logic [6:0]  bus_rate;
   bit          steady;
   bit          hold_rsp;
   int          sent_count;
   int          quiet_cycles;

   onewire_bus_master dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_mode             (req_mode),
      .req_write_data       (req_write_data),
      .req_bus_level        (req_bus_level),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_bus_drive_low    (rsp_bus_drive_low),
      .rsp_idle             (rsp_idle),
      .rsp_command_rejected (rsp_command_rejected),
      .rsp_presence_done    (rsp_presence_done),
      .rsp_presence_found   (rsp_presence_found),
      .rsp_read_done        (rsp_read_done),
      .rsp_read_value       (rsp_read_value),
      .rsp_write_done       (rsp_write_done),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // slot length in ticks as the driver sees it
   function automatic int slot_ticks(logic [US_WIDTH-1:0] us);
      logic [31:0] product;
      product = 32'(us) * 32'(bus_rate);
      return (product[15:0] == 16'd0) ? 1 : int'(product[15:0]);
   endfunction

   // ticks needed to bring a command started from idle back to idle
   function automatic int sequence_ticks(logic [2:0] mode, logic [7:0] data);
      int total = 0;
      int bits;
      bits = (mode == MODE_WRITE_BIT) ? 1 : 8;
      case (mode)
         MODE_RESET_PRES:
            total = slot_ticks(US_PRES_LOW) + slot_ticks(US_PRES_WAIT) + slot_ticks(US_PRES_REC);
         MODE_WRITE_BYTE, MODE_WRITE_BIT:
            for (int b = 0; b < bits; b++)
               total += data[b] ? slot_ticks(US_W1_LOW) + slot_ticks(US_W1_REC)
                                : slot_ticks(US_W0_LOW) + slot_ticks(US_W0_REC);
         MODE_READ_BYTE:
            total = 8 * (slot_ticks(US_RD_LOW) + slot_ticks(US_RD_WAIT) + slot_ticks(US_RD_REC));
         MODE_READ_BIT:
            total = slot_ticks(US_RD_LOW) + slot_ticks(US_RD_WAIT) + slot_ticks(US_RD_REC);
         default:
            total = 0;
      endcase
      return total;
   endfunction

   // 0 and 1 hold the line at that level, anything else picks at random
   function automatic logic line_level(int level_sel);
      return (level_sel > 1) ? 1'($urandom_range(1)) : 1'(level_sel);
   endfunction

   // offer one request and wait for it to be taken
   task automatic offer(input logic [2:0] mode, input logic [7:0] data, input logic level);
      while (!steady && $urandom_range(99) < 13) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_mode       <= mode;
      req_write_data <= data;
      req_bus_level  <= level;
      do @(posedge clock); while (!req_ready);
      sent_count++;
   endtask

   // one command followed by the ticks that finish it, with stray requests mixed in
   task automatic run_command(input logic [2:0] mode, input logic [7:0] data,
                              input int level_sel, input int noise_pct);
      int n;
      n = sequence_ticks(mode, data);
      offer(mode, data, line_level(level_sel));
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < noise_pct)
            offer(3'($urandom_range(1, 7)), 8'($urandom), 1'($urandom_range(1)));
         offer(MODE_TICK, 8'($urandom), line_level(level_sel));
      end
   endtask

   // stop offering until every awaited response is back
   task automatic drain_responses();
      req_valid <= 1'b0;
      do @(posedge clock); while (tracker.awaited_responses.size() != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic program_rate(input logic [6:0] value);
      drain_responses();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      bus_rate = value;
      tracker.set_rate(value);
   endtask

   // response side: random stalls, one long hold when asked
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_ready <= steady || ($urandom_range(99) >= 13);
         end
      end
   end

   // handshake monitor and watchdog
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (req_valid && req_ready)
            tracker.note_request(req_item_type'{req_mode, req_write_data, req_bus_level});
         if (rsp_valid && rsp_ready)
            tracker.check_response(rsp_item_type'{rsp_bus_drive_low, rsp_idle,
               rsp_command_rejected, rsp_presence_done, rsp_presence_found,
               rsp_read_done, rsp_read_value, rsp_write_done});
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("[onewire_bus_master] ERROR");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // stimulus
   initial begin
      int phase_base;
      tracker = new();
      bus_rate = TPU_RESET;
      steady = 1'b0;
      hold_rsp = 1'b0;
      sent_count = 0;
      req_valid      <= 1'b0;
      req_mode       <= MODE_TICK;
      req_write_data <= 8'h00;
      req_bus_level  <= 1'b1;
      csr_wr_en      <= 1'b0;
      csr_wr_data    <= '0;
      reset          <= 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset rate: idle tick, ignored modes, one bit slot of each kind
      run_command(MODE_TICK, 8'h00, 1, 0);
      run_command(MODE_UNUSED_6, 8'hFF, 0, 0);
      run_command(MODE_UNUSED_7, 8'h00, 1, 0);
      run_command(MODE_WRITE_BIT, {7'($urandom), 1'b1}, 2, 5);
      run_command(MODE_READ_BIT, 8'($urandom), 0, 0);

      // one tick per microsecond
      program_rate(7'd1);
      run_command(MODE_WRITE_BIT, 8'hFE, 2, 5);
      run_command(MODE_READ_BIT, 8'($urandom), 1, 0);

      // zero rate: every slot is a single tick
      program_rate(7'd0);
      run_command(MODE_RESET_PRES, 8'($urandom), 0, 0);
      run_command(MODE_RESET_PRES, 8'($urandom), 1, 5);
      run_command(MODE_WRITE_BYTE, 8'h00, 2, 0);
      run_command(MODE_WRITE_BYTE, 8'hFF, 2, 0);
      run_command(MODE_WRITE_BYTE, 8'hA5, 2, 5);
      run_command(MODE_READ_BYTE, 8'($urandom), 0, 0);
      run_command(MODE_READ_BYTE, 8'($urandom), 1, 0);
      run_command(MODE_READ_BYTE, 8'($urandom), 2, 5);
      run_command(MODE_WRITE_BIT, 8'h01, 2, 0);
      run_command(MODE_WRITE_BIT, 8'hFE, 2, 5);
      run_command(MODE_READ_BIT, 8'($urandom), 0, 0);
      run_command(MODE_READ_BIT, 8'($urandom), 1, 0);

      // random sequences, mostly well-formed commands with rejected and ignored requests
      for (int p = 0; p < 3; p++) begin
         steady = (p == 2);
         if (p == 1) hold_rsp = 1'b1;
         phase_base = sent_count;
         while (sent_count - phase_base < PHASE_REQUESTS) begin
            case ($urandom_range(19))
               0: run_command(MODE_RESET_PRES, 8'($urandom), 2, 5);
               1: run_command(MODE_TICK, 8'($urandom), 2, 0);
               2: run_command($urandom_range(1) ? MODE_UNUSED_6 : MODE_UNUSED_7,
                              8'($urandom), 2, 0);
               default: run_command(3'($urandom_range(MODE_WRITE_BYTE, MODE_READ_BIT)),
                                    8'($urandom), 2, 6);
            endcase
         end
      end
      steady = 1'b0;

      // wind down
      drain_responses();
      repeat (8) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.awaited_responses.size() == 0) begin
         $display("[onewire_bus_master] OK");
      end else begin
         $display("[onewire_bus_master] ERROR");
      end
      $finish;
   end

endmodule
